// ===== rtl/accumulator_machine_step_assert.svh =====
// Assertion macros for the accumulator machine.
// Included by the top level; no other dependencies.
`ifndef ACCUMULATOR_MACHINE_STEP_ASSERT_SVH
`define ACCUMULATOR_MACHINE_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define AMS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AMS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AMS_ASSERT(label, clk, rst_n, prop, msg)
`define AMS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/ams_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the accumulator machine.
// No dependencies; imported by every module of the block.
package ams_pkg;

	localparam int CNT_W  = 7;
	localparam int WORD_W = 32;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_STEP  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam logic [5:0] OP_READ   = 6'd10;
	localparam logic [5:0] OP_WRITE  = 6'd11;
	localparam logic [5:0] OP_LOAD   = 6'd20;
	localparam logic [5:0] OP_STORE  = 6'd21;
	localparam logic [5:0] OP_ADD    = 6'd30;
	localparam logic [5:0] OP_SUB    = 6'd31;
	localparam logic [5:0] OP_DIV    = 6'd32;
	localparam logic [5:0] OP_MUL    = 6'd33;
	localparam logic [5:0] OP_MOD    = 6'd34;
	localparam logic [5:0] OP_POW    = 6'd36;
	localparam logic [5:0] OP_BRANCH = 6'd40;
	localparam logic [5:0] OP_BRNEG  = 6'd41;
	localparam logic [5:0] OP_BRZERO = 6'd42;
	localparam logic [5:0] OP_HALT   = 6'd43;
	// console string opcode, executed as a no-op
	localparam logic [5:0] OP_STRING = 6'd50;

	// floor(n / 100) = (n * MAGIC) >> 37 for any n below 2^32
	localparam logic [30:0] DIV100_MAGIC = 31'h51EB851F;
	localparam int          DIV100_SHIFT = 37;
	localparam int          PROD_W       = 62;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_DIV0  = 3'd1,
		ERR_MOD0  = 3'd2,
		ERR_RANGE = 3'd3,
		ERR_POW0  = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_EXEC,
		ST_DIV,
		ST_POW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [CNT_W-1:0]        address;
		logic signed [WORD_W-1:0] value;
		logic signed [WORD_W-1:0] read_value;
	} item_t;

	typedef struct packed {
		logic                     running;
		logic                     out_valid;
		logic signed [WORD_W-1:0] out_data;
		logic                     read_taken;
		logic [2:0]               error;
		logic [CNT_W-1:0]         counter_now;
		logic signed [WORD_W-1:0] accumulator_now;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] quotient;
		logic [WORD_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] expo;
	} pow_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] result;
	} pow_rsp_t;

	function automatic logic is_mem_op(input logic [5:0] op);
		logic hit;
		hit = 1'b0;
		case (op) inside
			OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
			OP_DIV, OP_MUL, OP_MOD, OP_POW: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

// ===== rtl/ams_mem.sv =====
`timescale 1ns / 1ps
// Word store: one write port, one registered read port, valid bit per entry.
// Entries never written since reset or clear read as zero. Uses ams_pkg.
module ams_mem #(
	parameter int DEPTH = 100,
	parameter int AW    = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ams_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [ams_pkg::WORD_W-1:0] rdata
);
	import ams_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [WORD_W-1:0] rd_q;
	logic              rv_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			rv_q <= vld_q[raddr];
			if (clear) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rv_q ? rd_q : '0;

endmodule

// ===== rtl/ams_div.sv =====
`timescale 1ns / 1ps
// Signed truncating divider, restoring, one quotient bit per cycle.
// Uses ams_pkg request and response structs.
module ams_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ams_pkg::div_req_t req,
	output ams_pkg::div_rsp_t rsp
);
	import ams_pkg::*;

	localparam int STEP_W = $clog2(WORD_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
	logic              negq_q, negr_q;
	logic [WORD_W:0]   trial, diff;

	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(WORD_W);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend[WORD_W-1] ? -req.dividend : req.dividend;
			dvs_q  <= req.divisor[WORD_W-1] ? -req.divisor : req.divisor;
			rem_q  <= '0;
			negq_q <= req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
			negr_q <= req.dividend[WORD_W-1];
		end else if (busy_q && step_q != '0) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = busy_q && step_q == '0;
	assign rsp.quotient  = negq_q ? -quo_q : quo_q;
	assign rsp.remainder = negr_q ? -rem_q : rem_q;

endmodule

// ===== rtl/ams_pow.sv =====
`timescale 1ns / 1ps
// Square-and-multiply power unit, one shared 32x32 multiplier used in turn for
// multiply and square. Exponent must be non-negative. Uses ams_pkg structs.
module ams_pow (
	input  logic              clk,
	input  logic              arst_n,
	input  ams_pkg::pow_req_t req,
	output ams_pkg::pow_rsp_t rsp
);
	import ams_pkg::*;

	logic              busy_q, phase_q;
	logic [WORD_W-1:0] r_q, sq_q, u_q;
	logic [WORD_W-1:0] mul_a, prod;

	// phase 0 folds the current bit into r, phase 1 squares
	assign mul_a = phase_q ? sq_q : r_q;
	assign prod  = WORD_W'(mul_a * sq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (busy_q) begin
			if (u_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q  <= WORD_W'(1);
			sq_q <= req.base;
			u_q  <= req.expo;
		end else if (busy_q && u_q != '0) begin
			if (!phase_q) begin
				if (u_q[0]) begin
					r_q <= prod;
				end
			end else begin
				sq_q <= prod;
				u_q  <= u_q >> 1;
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = busy_q && u_q == '0;
	assign rsp.result = r_q;

endmodule

// ===== rtl/accumulator_machine_step.sv =====
// Decimal-coded accumulator machine, one item at a time.
// Input channel item_valid / item_stall / item: an item loads a memory word,
// clears the machine, executes the instruction at the counter or does nothing.
// Output channel result_valid / result_stall / result: exactly one result per
// item, in order, held in an output register while the receiver stalls; the
// next item is taken while that result waits, but its own result waits for it.
// cfg_we / cfg_wdata write the program end register; an accepted clear wins.
// Load, clear and idle steps go straight to the result register; ordinary
// instructions pass through instruction read, reciprocal multiply for the
// /100 decode, operand read, execute and result; divide and modulo wait on
// the bit-serial divider; power waits on the shared multiplier of the power
// unit for each exponent bit up to its top set bit.
// The next item can be taken in the cycle after a result is registered.
// Reset clears the accumulator, counter, program end and all memory valid
// bits at once; memory reads as zero until written. No clearing pass.
`timescale 1ns / 1ps
`include "accumulator_machine_step_assert.svh"
module accumulator_machine_step #(
	parameter int MEMORY_WORDS = 100
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  ams_pkg::item_t            item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output ams_pkg::result_t          result,
	input  logic                      cfg_we,
	input  logic [ams_pkg::CNT_W-1:0] cfg_wdata
);
	import ams_pkg::*;

	localparam int AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
	localparam logic [CNT_W-1:0] MEM_END = CNT_W'(MEMORY_WORDS);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q, pe_q, opd_q, exec_next;
	logic [WORD_W-1:0] acc_q, word_q, rv_q, od_q;
	logic [5:0]        op_q;
	logic [PROD_W-1:0] prod_q;
	logic              ov_q, rt_q;
	err_t              err_q;
	logic              res_valid_q;
	result_t           res_q;

	logic              mem_we, mem_clear;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;
	pow_req_t pow_req;
	pow_rsp_t pow_rsp;

	logic accept, out_free, step_live, step_oob, exec_fault;
	logic [PROD_W-DIV100_SHIFT-1:0] quo100;
	logic [WORD_W-1:0] rem_full;
	logic [5:0]        dec_op;
	logic [CNT_W-1:0]  dec_opd;
	logic              opd_in_mem, dec_bad;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !res_valid_q || !result_stall;
	assign step_live  = (cnt_q != pe_q);
	assign step_oob   = step_live && (cnt_q >= MEM_END);

	// opcode = word / 100, operand = word % 100; negative words decode to no-ops
	assign quo100     = prod_q[PROD_W-1:DIV100_SHIFT];
	assign rem_full   = word_q - WORD_W'(WORD_W'(quo100) * WORD_W'(100));
	assign dec_op     = (word_q[WORD_W-1] || quo100 > 63) ? 6'd0 : quo100[5:0];
	assign dec_opd    = rem_full[CNT_W-1:0];
	assign opd_in_mem = dec_opd < MEM_END;
	assign dec_bad    = is_mem_op(dec_op) && !opd_in_mem;

	// execute-stage errors that halt the machine
	assign exec_fault = ((op_q == OP_DIV || op_q == OP_MOD) && mem_rdata == '0) ||
		(op_q == OP_POW && mem_rdata[WORD_W-1] && acc_q == '0);

	always_comb begin
		case (op_q)
			OP_BRANCH: exec_next = opd_q;
			OP_BRNEG:  exec_next = acc_q[WORD_W-1] ? opd_q : cnt_q + 1'b1;
			OP_BRZERO: exec_next = (acc_q == '0) ? opd_q : cnt_q + 1'b1;
			OP_HALT:   exec_next = pe_q;
			default:   exec_next = cnt_q + 1'b1;
		endcase
	end

	ams_mem #(
		.DEPTH(MEMORY_WORDS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.clear(mem_clear),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ams_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	ams_pow u_pow (
		.clk(clk),
		.arst_n(arst_n),
		.req(pow_req),
		.rsp(pow_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_clear = 1'b0;
		mem_waddr = opd_q[AW-1:0];
		mem_wdata = acc_q;
		mem_raddr = '0;
		div_req   = '{start: 1'b0, dividend: acc_q, divisor: mem_rdata};
		pow_req   = '{start: 1'b0, base: acc_q, expo: mem_rdata};
		case (state_q)
			ST_IDLE: begin
				mem_raddr = (cnt_q < MEM_END) ? cnt_q[AW-1:0] : '0;
				if (accept) begin
					state_d = ST_DONE;
					case (item.kind)
						KIND_LOAD: begin
							mem_we    = item.address < MEM_END;
							mem_waddr = item.address[AW-1:0];
							mem_wdata = item.value;
						end
						KIND_STEP: begin
							if (step_live && !step_oob) state_d = ST_FETCH;
						end
						KIND_CLEAR: mem_clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_FETCH: state_d = ST_DECODE;
			ST_DECODE: begin
				mem_raddr = opd_in_mem ? dec_opd[AW-1:0] : '0;
				state_d   = dec_bad ? ST_DONE : ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (op_q)
					OP_READ: begin
						mem_we    = 1'b1;
						mem_wdata = rv_q;
					end
					OP_STORE: mem_we = 1'b1;
					OP_DIV, OP_MOD: begin
						if (mem_rdata != '0) begin
							div_req.start = 1'b1;
							state_d       = ST_DIV;
						end
					end
					OP_POW: begin
						if (!mem_rdata[WORD_W-1]) begin
							pow_req.start = 1'b1;
							state_d       = ST_POW;
						end
					end
					default: ;
				endcase
			end
			ST_DIV: if (div_rsp.done) state_d = ST_DONE;
			ST_POW: if (pow_rsp.done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// architectural registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			acc_q       <= '0;
			pe_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept && item.kind == KIND_CLEAR) pe_q <= '0;
			else if (cfg_we) pe_q <= cfg_wdata;
			if (state_q == ST_DONE && out_free) res_valid_q <= 1'b1;
			else if (result_valid && !result_stall) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && item.kind == KIND_CLEAR) begin
						acc_q <= '0;
						cnt_q <= '0;
					end
					if (accept && item.kind == KIND_STEP && step_oob) cnt_q <= pe_q;
				end
				ST_DECODE: if (dec_bad) cnt_q <= pe_q;
				ST_EXEC: begin
					cnt_q <= exec_fault ? pe_q : exec_next;
					case (op_q)
						OP_LOAD: acc_q <= mem_rdata;
						OP_ADD:  acc_q <= acc_q + mem_rdata;
						OP_SUB:  acc_q <= acc_q - mem_rdata;
						OP_MUL:  acc_q <= WORD_W'(acc_q * mem_rdata);
						OP_POW: begin
							// negative exponent: only 1 and -1 survive
							if (mem_rdata[WORD_W-1] && acc_q != '0) begin
								if (acc_q == WORD_W'(1)) begin
									acc_q <= WORD_W'(1);
								end else if (acc_q == '1) begin
									acc_q <= mem_rdata[0] ? '1 : WORD_W'(1);
								end else begin
									acc_q <= '0;
								end
							end
						end
						default: ;
					endcase
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						acc_q <= (op_q == OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
					end
				end
				ST_POW: if (pow_rsp.done) acc_q <= pow_rsp.result;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ov_q  <= 1'b0;
					rt_q  <= 1'b0;
					od_q  <= '0;
					rv_q  <= item.read_value;
					err_q <= (item.kind == KIND_STEP && step_oob) ? ERR_RANGE : ERR_NONE;
				end
			end
			ST_FETCH: begin
				word_q <= mem_rdata;
				prod_q <= mem_rdata[WORD_W-2:0] * DIV100_MAGIC;
			end
			ST_DECODE: begin
				op_q  <= dec_op;
				opd_q <= dec_opd;
				if (dec_bad) err_q <= ERR_RANGE;
			end
			ST_EXEC: begin
				case (op_q)
					OP_READ: rt_q <= 1'b1;
					OP_WRITE: begin
						ov_q <= 1'b1;
						od_q <= mem_rdata;
					end
					OP_DIV: if (mem_rdata == '0) err_q <= ERR_DIV0;
					OP_MOD: if (mem_rdata == '0) err_q <= ERR_MOD0;
					OP_POW: if (mem_rdata[WORD_W-1] && acc_q == '0) err_q <= ERR_POW0;
					default: ;
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					res_q <= '{running: step_live, out_valid: ov_q, out_data: od_q,
						read_taken: rt_q, error: err_q, counter_now: cnt_q,
						accumulator_now: acc_q};
				end
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`AMS_ASSERT(a_accept_leaves_idle, clk, arst_n, (item_valid && !item_stall) |=> (state_q != ST_IDLE), "accepted item did not start work")
	`AMS_ASSERT(a_done_delivers, clk, arst_n, (state_q == ST_DONE && out_free) |=> (result_valid && state_q == ST_IDLE), "finished item not delivered")
	`AMS_ASSERT(a_div_running, clk, arst_n, (state_q == ST_DIV) |-> div_rsp.busy, "waiting on an idle divider")
	`AMS_ASSERT_NEVER(a_units_exclusive, clk, arst_n, div_rsp.busy && pow_rsp.busy, "divider and power unit busy together")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for accumulator_machine_step: random programs and noise items,
// results checked against an in-bench model of the machine. Depends on ams_pkg and the RTL.
module tb;
	import ams_pkg::*;

	localparam int MEM_WORDS  = 100;
	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 400;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	item_t                  item_bus = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result_bus;
	logic                   cfg_we = 1'b0;
	logic [CNT_W-1:0]       cfg_wdata = '0;

	accumulator_machine_step dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item_bus),
		.result_valid(result_valid), .result_stall(result_stall), .result(result_bus),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// machine model state
	logic [WORD_W-1:0] mem_words [MEM_WORDS];
	logic [WORD_W-1:0] acc;
	logic [CNT_W-1:0]  pc;
	logic [CNT_W-1:0]  prog_end;

	item_t   pending_items[$];
	result_t predicted_results[$];
	int      mismatches = 0;
	int      send_gap_max = 7;
	int      stall_max = 7;
	int      results_seen = 0;
	int      idle_cycles = 0;

	initial forever #2 clk = ~clk;

	function automatic void clear_machine();
		for (int i = 0; i < MEM_WORDS; i++) mem_words[i] = '0;
		acc = '0;
		pc = '0;
		prog_end = '0;
	endfunction

	function automatic logic [WORD_W-1:0] raise(input logic [WORD_W-1:0] base,
			input logic [WORD_W-1:0] expo, inout logic [2:0] e);
		logic [WORD_W-1:0] r, sq, u;
		r = 32'd1;
		sq = base;
		u = expo;
		if (expo[31]) begin
			if (base == 0) begin
				e = ERR_POW0;
				return base;
			end
			if (base == 32'd1) return 32'd1;
			if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
			return 32'd0;
		end
		while (u != 0) begin
			if (u[0]) r = r * sq;
			sq = sq * sq;
			u = u >> 1;
		end
		return r;
	endfunction

	function automatic result_t machine_step(input item_t it);
		result_t r;
		logic [2:0] e;
		int w, opc, opd, idx;
		logic [CNT_W-1:0] nxt;
		logic [WORD_W-1:0] m;
		logic mem_op;
		r = '0;
		e = ERR_NONE;
		case (it.kind)
			KIND_LOAD: if (it.address < MEM_WORDS) mem_words[it.address] = it.value;
			KIND_CLEAR: clear_machine();
			KIND_STEP: if (pc != prog_end) begin
				if (pc >= MEM_WORDS) begin
					e = ERR_RANGE;
				end else begin
					w = $signed(mem_words[pc]);
					opc = w / 100;
					opd = w % 100;
					nxt = pc + 1'b1;
					mem_op = opc inside {OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD,
						OP_SUB, OP_DIV, OP_MUL, OP_MOD, OP_POW};
					if (mem_op && (opd < 0 || opd >= MEM_WORDS)) begin
						e = ERR_RANGE;
					end else begin
						idx = (opd >= 0 && opd < MEM_WORDS) ? opd : 0;
						m = mem_words[idx];
						case (opc)
							OP_READ: begin
								mem_words[idx] = it.read_value;
								r.read_taken = 1'b1;
							end
							OP_WRITE: begin
								r.out_valid = 1'b1;
								r.out_data = m;
							end
							OP_LOAD:  acc = m;
							OP_STORE: mem_words[idx] = acc;
							OP_ADD:   acc = acc + m;
							OP_SUB:   acc = acc - m;
							OP_MUL:   acc = acc * m;
							OP_DIV, OP_MOD: begin
								if (m == 0) e = (opc == OP_DIV) ? ERR_DIV0 : ERR_MOD0;
								else if (acc == 32'h8000_0000 && m == 32'hFFFF_FFFF)
									acc = (opc == OP_DIV) ? 32'h8000_0000 : 32'd0;
								else if (opc == OP_DIV) acc = $signed(acc) / $signed(m);
								else acc = $signed(acc) % $signed(m);
							end
							OP_POW:    acc = raise(acc, m, e);
							OP_BRANCH: nxt = opd[CNT_W-1:0];
							OP_BRNEG:  if (acc[31]) nxt = opd[CNT_W-1:0];
							OP_BRZERO: if (acc == 0) nxt = opd[CNT_W-1:0];
							OP_HALT:   nxt = prog_end;
							default: ;
						endcase
						if (e == ERR_NONE) pc = nxt;
					end
				end
				if (e != ERR_NONE) pc = prog_end;
			end
			default: ;
		endcase
		r.running = (pc != prog_end);
		r.error = e;
		r.counter_now = pc;
		r.accumulator_now = acc;
		return r;
	endfunction

	// driver: one item per handshake, random gap drawn after each pop
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) predicted_results.push_back(machine_step(item_bus));
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item_bus <= pending_items.pop_front();
					item_valid <= 1'b1;
					gap_left <= $urandom_range(0, send_gap_max);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: per-result stall draw, plus one long hold-off to fill the block
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		result_t want;
		int nxt_stall;
		nxt_stall = stall_left;
		if (hold_left > 0) hold_left <= hold_left - 1;
		if (result_valid && !result_stall) begin
			results_seen <= results_seen + 1;
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", result_bus);
			end else begin
				want = predicted_results.pop_front();
				if (result_bus !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("result mismatch: expected %p got %p",
						want, result_bus);
				end
			end
			nxt_stall = $urandom_range(0, stall_max);
		end else if (result_valid && stall_left > 0) begin
			nxt_stall = stall_left - 1;
		end
		stall_left <= nxt_stall;
		if (!hold_done && results_seen == 300) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (hold_left > 1) || (nxt_stall > 0);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("accumulator_machine_step: mismatch");
			$finish;
		end
	end

	function automatic item_t mk(input logic [1:0] k, input int addr, input int val,
			input int rd);
		item_t it;
		it.kind = k;
		it.address = CNT_W'(addr);
		it.value = val;
		it.read_value = rd;
		return it;
	endfunction

	task automatic drain();
		@(posedge clk);
		while (pending_items.size() != 0 || item_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_end(input int v);
		cfg_we <= 1'b1;
		cfg_wdata <= CNT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		prog_end = CNT_W'(v);
		@(posedge clk);
	endtask

	task automatic put_load(input int addr, input int val);
		pending_items.push_back(mk(KIND_LOAD, addr, val, $urandom));
	endtask

	task automatic put_steps(input int n);
		repeat (n) pending_items.push_back(mk(KIND_STEP, $urandom_range(0, 127), $urandom,
			$urandom));
	endtask

	function automatic int data_word();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return -1;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			5: return $urandom_range(0, 40) - 20;
			6: return $urandom_range(0, 9999);
			default: return $urandom;
		endcase
	endfunction

	function automatic int instr_word(input int len);
		int ops[15] = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV,
			OP_MUL, OP_MOD, OP_POW, OP_BRANCH, OP_BRNEG, OP_BRZERO, OP_HALT, OP_STRING};
		int op, opd;
		if ($urandom_range(0, 19) == 0) return $urandom;
		if ($urandom_range(0, 19) == 0) return -$urandom_range(0, 9999);
		op = ops[$urandom_range(0, 14)];
		if (op == OP_HALT && $urandom_range(0, 2) != 0) op = OP_ADD;
		if (op inside {OP_BRANCH, OP_BRNEG, OP_BRZERO})
			opd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99)
				: $urandom_range(0, len);
		else
			opd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99)
				: $urandom_range(80, 99);
		return op * 100 + opd;
	endfunction

	int sent = 0;
	initial begin
		int len, pe, n;
		clear_machine();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stopped machine, loads outside memory, unused kind, overflow cases
		put_load(127, 5);
		put_load(100, 7);
		pending_items.push_back(mk(KIND_SPARE, 127, -1, -1));
		put_steps(1);
		put_load(0, 2090);
		put_load(1, 3291);
		put_load(2, 3491);
		put_load(3, 3693);
		put_load(90, 32'h8000_0000);
		put_load(91, -1);
		put_load(93, -3);
		drain();
		set_end(100);
		put_steps(4);
		drain();
		// negative exponent of -1, zero exponent, divide by zero
		pending_items.push_back(mk(KIND_CLEAR, 0, 0, 0));
		drain();
		set_end(100);
		put_load(0, 2094);
		put_load(1, 3693);
		put_load(2, 3692);
		put_load(3, 3295);
		put_load(93, -3);
		put_load(94, -1);
		put_steps(4);
		drain();
		// counter walks off the end of memory
		pending_items.push_back(mk(KIND_CLEAR, 0, 0, 0));
		drain();
		set_end(5);
		put_load(0, 4099);
		put_steps(3);
		drain();

		while (sent < 1200) begin
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			if ($urandom_range(0, 7) != 0) begin
				pending_items.push_back(mk(KIND_CLEAR, $urandom_range(0, 127), $urandom,
					$urandom));
				drain();
			end
			len = $urandom_range(3, 24);
			case ($urandom_range(0, 19))
				0: pe = 0;
				1, 2: pe = 100;
				3: pe = $urandom_range(0, 100);
				default: pe = len;
			endcase
			set_end(pe);
			for (int a = 0; a < len; a++) put_load(a, instr_word(len));
			repeat ($urandom_range(4, 12)) put_load($urandom_range(80, 99), data_word());
			n = $urandom_range(20, 50);
			for (int s = 0; s < n; s++) begin
				case ($urandom_range(0, 49))
					0, 1, 2: put_load($urandom_range(0, 127), $urandom);
					3: pending_items.push_back(mk(KIND_SPARE, $urandom_range(0, 127),
						$urandom, $urandom));
					4: if ($urandom_range(0, 3) == 0)
						pending_items.push_back(mk(KIND_CLEAR, 0, 0, 0));
					default: put_steps(1);
				endcase
			end
			sent += len + n + 8;
			drain();
		end

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && predicted_results.size() == 0)
			$display("accumulator_machine_step: match");
		else
			$display("accumulator_machine_step: mismatch");
		$finish;
	end
endmodule
